[rtl/core/tsc_pkg.sv]
// Shared constants and register indexes of the touch sample conditioner.
package tsc_pkg;

	localparam int SAMPLE_W = 12;
	localparam int PRESS_W  = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int ORIENT_W = 3;

	// Width of the divider's numerator shift register and its step counter.
	localparam int NUM_W  = 2 * SAMPLE_W;
	localparam int STEP_W = 5;

	// Averaged z1 must exceed this for the pressure to be computed.
	localparam logic [SAMPLE_W-1:0] Z1_FLOOR = 12'd10;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_X_MIN        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_MAX        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Y_MIN        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_MAX        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_MIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_MAX = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ORIENTATION  = 3'd6;

	// Reset values of the configuration registers.
	localparam logic [SAMPLE_W-1:0] X_MIN_RST        = 12'd200;
	localparam logic [SAMPLE_W-1:0] X_MAX_RST        = 12'd3900;
	localparam logic [SAMPLE_W-1:0] Y_MIN_RST        = 12'd200;
	localparam logic [SAMPLE_W-1:0] Y_MAX_RST        = 12'd3900;
	localparam logic [PRESS_W-1:0]  PRESSURE_MIN_RST = 16'd30;
	localparam logic [PRESS_W-1:0]  PRESSURE_MAX_RST = 16'd255;
	localparam logic [ORIENT_W-1:0] ORIENTATION_RST  = 3'd0;

	// Orientation bits.
	localparam int ORIENT_SWAP  = 0;
	localparam int ORIENT_INV_X = 1;
	localparam int ORIENT_INV_Y = 2;

endpackage

[rtl/core/touch_sample_conditioner_unit.sv]
// Top level of the touch sample conditioner: averaging, pressure, calibration and reporting.
// Sequence: a round that does not complete a set is taken with no result; a completing
// round runs four averaging multiplies, the product, NUM_W divider steps, finish and emit,
// skipping the divider steps when z1 is too low or x is zero, and emit when not reported.
// Throughput: one request at a time, plus output stalls; a pen-up with a release goes through emit.
// Reset (arst_n low, asynchronous): state and registers return to defaults, no result pending.
module touch_sample_conditioner_unit #(
	parameter int SAMPLES = 3
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write channel.
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [tsc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tsc_pkg::CFG_DATA_W-1:0]     cfg_data,
	// Input request channel.
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               pen_down,
	input  logic [tsc_pkg::SAMPLE_W-1:0]       sample_x,
	input  logic [tsc_pkg::SAMPLE_W-1:0]       sample_y,
	input  logic [tsc_pkg::SAMPLE_W-1:0]       sample_z1,
	input  logic [tsc_pkg::SAMPLE_W-1:0]       sample_z2,
	// Result channel.
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [tsc_pkg::SAMPLE_W-1:0]       pos_x,
	output logic [tsc_pkg::SAMPLE_W-1:0]       pos_y,
	output logic [tsc_pkg::PRESS_W-1:0]        pressure,
	output logic                               touching
);
	import tsc_pkg::*;

	// A sum holds SAMPLES rounds of full-scale samples.
	localparam int SUM_W = SAMPLE_W + $clog2(SAMPLES);
	// The round counter only needs to count up to SAMPLES-1.
	localparam int CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES - 1);
	localparam logic [STEP_W-1:0] PROD_STEPS_LAST = STEP_W'(NUM_W - 1);
	// Averages use a rounded-up reciprocal of SAMPLES, exact for every sum below 2**SUM_W.
	localparam int RECIP_SHIFT = SUM_W + $clog2(SAMPLES);
	localparam int RECIP_W     = SUM_W + 2;
	localparam int AVG_PROD_W  = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_M =
		RECIP_W'(((1 << RECIP_SHIFT) + SAMPLES - 1) / SAMPLES);

	typedef enum logic [2:0] {
		ST_IDLE,     // waiting for a request
		ST_AVG,      // one sum divided by SAMPLES per cycle
		ST_MUL,      // x times |z2 - z1| into the divider, or zero pressure
		ST_PDIV,     // product divided by z1, one bit per cycle
		ST_FINISH,   // clip, orient, clamp and decide whether to report
		ST_EMIT      // hand the pending result to the output register
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [SAMPLE_W-1:0] x_min_q, x_max_q, y_min_q, y_max_q;
	logic [PRESS_W-1:0]  pressure_min_q, pressure_max_q;
	logic [ORIENT_W-1:0] orientation_q;

	// Accumulation state.
	logic [SUM_W-1:0] sum_x_q, sum_y_q, sum_z1_q, sum_z2_q;
	logic [CNT_W-1:0] round_q;
	logic             touch_reported_q;

	// Divider: the numerator shifts out at the top while quotient bits enter at the bottom.
	logic [NUM_W-1:0]    num_q;
	logic [SAMPLE_W-1:0] rem_q;
	logic [SAMPLE_W-1:0] div_q;
	logic [STEP_W-1:0]   step_q;
	logic [1:0]          sel_q;

	// Averages in the order x, y, z1, z2; negative pressure flag and raw pressure.
	logic [SAMPLE_W-1:0] avg_q [4];
	logic                neg_q;
	logic [PRESS_W-1:0]  press_raw_q;

	// Pending result waiting for the output register.
	logic [SAMPLE_W-1:0] res_x_q, res_y_q;
	logic [PRESS_W-1:0]  res_p_q;
	logic                res_t_q;

	// Output register.
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] pos_x_q, pos_y_q;
	logic [PRESS_W-1:0]  pressure_q;
	logic                touching_q;

	logic in_take;
	logic out_free;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	// The output register can be loaded when it is empty or being emptied in this cycle.
	assign out_free  = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;
	assign pressure  = pressure_q;
	assign touching  = touching_q;

	// One restoring division step.
	logic [SAMPLE_W:0]   rem_shift;
	logic                quo_bit;
	logic [SAMPLE_W-1:0] rem_nxt;
	logic [NUM_W-1:0]    num_nxt;

	always_comb begin
		rem_shift = {rem_q, num_q[NUM_W-1]};
		quo_bit   = (rem_shift >= {1'b0, div_q});
		rem_nxt   = quo_bit ? SAMPLE_W'(rem_shift - {1'b0, div_q}) : rem_shift[SAMPLE_W-1:0];
		num_nxt   = {num_q[NUM_W-2:0], quo_bit};
	end

	// Sum selected for the next average.
	logic [SUM_W-1:0] sum_sel;

	always_comb begin
		case (sel_q)
			2'd0:    sum_sel = sum_x_q;
			2'd1:    sum_sel = sum_y_q;
			2'd2:    sum_sel = sum_z1_q;
			default: sum_sel = sum_z2_q;
		endcase
	end

	// Average of the selected sum by reciprocal multiplication; it always fits twelve bits.
	logic [AVG_PROD_W-1:0] avg_prod;
	logic [SAMPLE_W-1:0]   avg_quot;

	always_comb begin
		avg_prod = AVG_PROD_W'(sum_sel) * AVG_PROD_W'(RECIP_M);
		avg_quot = avg_prod[RECIP_SHIFT +: SAMPLE_W];
	end

	// Signed difference z2 - z1 as sign and magnitude.
	logic [SAMPLE_W:0]   diff_z;
	logic [SAMPLE_W-1:0] diff_mag;
	logic                press_ok;

	always_comb begin
		diff_z   = {1'b0, avg_q[3]} - {1'b0, avg_q[2]};
		diff_mag = diff_z[SAMPLE_W] ? SAMPLE_W'(-diff_z) : diff_z[SAMPLE_W-1:0];
		press_ok = (avg_q[2] > Z1_FLOOR) && (avg_q[0] != '0);
	end

	// Finishing arithmetic: clip the pressure, then swap, clamp and invert the coordinates.
	logic [PRESS_W-1:0]  press_clip;
	logic [SAMPLE_W-1:0] cx_sw, cy_sw, cx_cl, cy_cl, cx_fin, cy_fin;
	logic                report;

	always_comb begin
		press_clip = (press_raw_q > pressure_max_q) ? pressure_max_q : press_raw_q;

		cx_sw = orientation_q[ORIENT_SWAP] ? avg_q[1] : avg_q[0];
		cy_sw = orientation_q[ORIENT_SWAP] ? avg_q[0] : avg_q[1];

		// With crossed bounds the lower test wins.
		if (cx_sw < x_min_q) begin
			cx_cl = x_min_q;
		end else if (cx_sw > x_max_q) begin
			cx_cl = x_max_q;
		end else begin
			cx_cl = cx_sw;
		end
		if (cy_sw < y_min_q) begin
			cy_cl = y_min_q;
		end else if (cy_sw > y_max_q) begin
			cy_cl = y_max_q;
		end else begin
			cy_cl = cy_sw;
		end

		// Inversion wraps in twelve bits.
		cx_fin = orientation_q[ORIENT_INV_X] ? (x_max_q - (cx_cl - x_min_q)) : cx_cl;
		cy_fin = orientation_q[ORIENT_INV_Y] ? (y_max_q - (cy_cl - y_min_q)) : cy_cl;

		report = (press_clip >= pressure_min_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			x_min_q          <= X_MIN_RST;
			x_max_q          <= X_MAX_RST;
			y_min_q          <= Y_MIN_RST;
			y_max_q          <= Y_MAX_RST;
			pressure_min_q   <= PRESSURE_MIN_RST;
			pressure_max_q   <= PRESSURE_MAX_RST;
			orientation_q    <= ORIENTATION_RST;
			sum_x_q          <= '0;
			sum_y_q          <= '0;
			sum_z1_q         <= '0;
			sum_z2_q         <= '0;
			round_q          <= '0;
			touch_reported_q <= 1'b0;
			num_q            <= '0;
			rem_q            <= '0;
			div_q            <= '0;
			step_q           <= '0;
			sel_q            <= '0;
			avg_q            <= '{default: '0};
			neg_q            <= 1'b0;
			press_raw_q      <= '0;
			res_x_q          <= '0;
			res_y_q          <= '0;
			res_p_q          <= '0;
			res_t_q          <= 1'b0;
			out_valid_q      <= 1'b0;
			pos_x_q          <= '0;
			pos_y_q          <= '0;
			pressure_q       <= '0;
			touching_q       <= 1'b0;
		end else begin
			// The result is taken downstream and nothing new replaces it in this cycle.
			if (out_valid_q && !out_stall && (state_q != ST_EMIT)) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_X_MIN:        x_min_q        <= cfg_data[SAMPLE_W-1:0];
					REG_X_MAX:        x_max_q        <= cfg_data[SAMPLE_W-1:0];
					REG_Y_MIN:        y_min_q        <= cfg_data[SAMPLE_W-1:0];
					REG_Y_MAX:        y_max_q        <= cfg_data[SAMPLE_W-1:0];
					REG_PRESSURE_MIN: pressure_min_q <= cfg_data[PRESS_W-1:0];
					REG_PRESSURE_MAX: pressure_max_q <= cfg_data[PRESS_W-1:0];
					REG_ORIENTATION:  orientation_q  <= cfg_data[ORIENT_W-1:0];
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						if (!pen_down) begin
							// Pen lifted: drop the partial set and release a reported touch.
							sum_x_q  <= '0;
							sum_y_q  <= '0;
							sum_z1_q <= '0;
							sum_z2_q <= '0;
							round_q  <= '0;
							if (touch_reported_q) begin
								touch_reported_q <= 1'b0;
								res_x_q          <= '0;
								res_y_q          <= '0;
								res_p_q          <= '0;
								res_t_q          <= 1'b0;
								state_q          <= ST_EMIT;
							end
						end else begin
							sum_x_q  <= sum_x_q + SUM_W'(sample_x);
							sum_y_q  <= sum_y_q + SUM_W'(sample_y);
							sum_z1_q <= sum_z1_q + SUM_W'(sample_z1);
							sum_z2_q <= sum_z2_q + SUM_W'(sample_z2);
							if (round_q == CNT_LAST) begin
								round_q <= '0;
								sel_q   <= '0;
								state_q <= ST_AVG;
							end else begin
								round_q <= round_q + 1'b1;
							end
						end
					end
				end

				ST_AVG: begin
					avg_q[sel_q] <= avg_quot;
					if (sel_q == 2'd3) begin
						sum_x_q  <= '0;
						sum_y_q  <= '0;
						sum_z1_q <= '0;
						sum_z2_q <= '0;
						state_q  <= ST_MUL;
					end else begin
						sel_q <= sel_q + 1'b1;
					end
				end

				ST_MUL: begin
					if (press_ok) begin
						num_q   <= NUM_W'(avg_q[0]) * NUM_W'(diff_mag);
						rem_q   <= '0;
						div_q   <= avg_q[2];
						step_q  <= '0;
						neg_q   <= diff_z[SAMPLE_W];
						state_q <= ST_PDIV;
					end else begin
						press_raw_q <= '0;
						state_q     <= ST_FINISH;
					end
				end

				ST_PDIV: begin
					num_q  <= num_nxt;
					rem_q  <= rem_nxt;
					step_q <= step_q + 1'b1;
					if (step_q == PROD_STEPS_LAST) begin
						// Quotient truncates toward zero, then wraps to sixteen bits.
						press_raw_q <= neg_q ? PRESS_W'(-num_nxt) : num_nxt[PRESS_W-1:0];
						state_q     <= ST_FINISH;
					end
				end

				ST_FINISH: begin
					if (report) begin
						touch_reported_q <= 1'b1;
						res_x_q          <= cx_fin;
						res_y_q          <= cy_fin;
						res_p_q          <= press_clip;
						res_t_q          <= 1'b1;
						state_q          <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end

				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						pos_x_q     <= res_x_q;
						pos_y_q     <= res_y_q;
						pressure_q  <= res_p_q;
						touching_q  <= res_t_q;
						state_q     <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
